>>> rtl/qdit_pkg.sv
// Shared types, codes and the quadrature step table for the decoder.
package qdit_pkg;

    localparam logic        OP_PIN             = 1'b0;
    localparam logic        OP_UPDATE          = 1'b1;
    localparam logic [31:0] ZERO_INTERVAL_RST  = 32'd1000000;

    typedef logic signed [2:0] step_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic take_pin;
        logic take_upd;
        logic div_start;
        logic commit;
    } qdit_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic zero_case;
        logic div_done;
    } qdit_sts_t;

    // Index is {new B, new A, old B, old A}.
    function automatic step_t qdit_step(input logic [3:0] idx);
        step_t s;
        case (idx)
            4'd0:    s = 3'sd0;
            4'd1:    s = 3'sd1;
            4'd2:    s = -3'sd1;
            4'd3:    s = 3'sd2;
            4'd4:    s = -3'sd1;
            4'd5:    s = 3'sd0;
            4'd6:    s = -3'sd2;
            4'd7:    s = 3'sd1;
            4'd8:    s = 3'sd1;
            4'd9:    s = -3'sd2;
            4'd10:   s = 3'sd0;
            4'd11:   s = -3'sd1;
            4'd12:   s = 3'sd2;
            4'd13:   s = -3'sd1;
            4'd14:   s = 3'sd1;
            4'd15:   s = 3'sd0;
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/qdit_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module qdit_mod
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    logic [31:0] rem_reg,  rem_next;
    logic [31:0] dvd_reg,  dvd_next;
    logic [31:0] dsr_reg,  dsr_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // Zero divisor: every trial subtracts nothing, so the dividend comes out.
    assign trial = {rem_reg, dvd_reg[31]};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = trial[31:0] - dsr_reg;
            else
                rem_next = trial[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/qdit_dp.sv
// Datapath: decoder state, elapsed time, remainder unit and result register.
module qdit_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  qdit_pkg::qdit_cmd_t cmd,
    output qdit_pkg::qdit_sts_t sts,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              pin_a,
    input  logic              pin_b,
    input  logic [31:0]       now_us,
    output logic [31:0]       interval_us,
    output logic [31:0]       delta,
    output logic [31:0]       position
);
    import qdit_pkg::*;

    logic [31:0] zero_int_reg;
    logic [1:0]  prev_reg,     prev_next;
    logic [31:0] pending_reg,  pending_next;
    logic [31:0] base_reg,     base_next;
    logic [31:0] pos_reg,      pos_next;
    logic [31:0] now_reg;
    logic [31:0] elapsed_reg;
    logic [31:0] ivl_reg,      ivl_next;
    logic [31:0] dlt_reg,      dlt_next;
    logic [31:0] opos_reg,     opos_next;
    logic [31:0] rem;
    logic        div_done;
    step_t       step;

    assign step = qdit_step({pin_b, pin_a, prev_reg});

    qdit_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (elapsed_reg),
        .divisor   (zero_int_reg),
        .done      (div_done),
        .remainder (rem)
    );

    // Inputs to this stay put during an update if cfg writes come only while idle.
    assign sts.zero_case = (pending_reg == 32'd0) && (elapsed_reg >= zero_int_reg);
    assign sts.div_done  = div_done;

    always_comb
    begin
        prev_next    = prev_reg;
        pending_next = pending_reg;
        base_next    = base_reg;
        pos_next     = pos_reg;
        ivl_next     = ivl_reg;
        dlt_next     = dlt_reg;
        opos_next    = opos_reg;
        if (cmd.take_pin)
        begin
            pending_next = pending_reg + {{29{step[2]}}, step};
            prev_next    = {pin_b, pin_a};
        end
        if (cmd.commit)
        begin
            if (sts.zero_case)
            begin
                ivl_next  = rem;
                base_next = now_reg - rem;
                dlt_next  = '0;
                opos_next = pos_reg;
            end
            else
            begin
                ivl_next     = elapsed_reg;
                base_next    = now_reg;
                dlt_next     = pending_reg;
                pending_next = '0;
                pos_next     = pos_reg + pending_reg;
                opos_next    = pos_reg + pending_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_int_reg <= ZERO_INTERVAL_RST;
            prev_reg     <= '0;
            pending_reg  <= '0;
            base_reg     <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                zero_int_reg <= cfg_wdata;
            prev_reg    <= prev_next;
            pending_reg <= pending_next;
            base_reg    <= base_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_upd)
        begin
            now_reg     <= now_us;
            elapsed_reg <= now_us - base_reg;
        end
        ivl_reg  <= ivl_next;
        dlt_reg  <= dlt_next;
        opos_reg <= opos_next;
    end

    assign interval_us = ivl_reg;
    assign delta       = dlt_reg;
    assign position    = opos_reg;

endmodule

>>> rtl/qdit_ctrl.sv
// Controller: input handshake, update sequencing and output valid.
module qdit_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output qdit_pkg::qdit_cmd_t cmd,
    input  qdit_pkg::qdit_sts_t sts
);
    import qdit_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   take;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;
    assign out_free = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        cmd.take_pin  = take && (in_op == OP_PIN);
        cmd.take_upd  = take && (in_op == OP_UPDATE);
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take_upd)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.zero_case)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

>>> rtl/quadrature_decoder_with_interval_timer_unit.sv
// Top level: 4x quadrature decoder with periodic interval reports.
//
// Input stream: tuser is the item kind (0 pin sample, 1 update request).
// A pin sample (A, B levels) adds the table step
// to the pending delta and gives no output transfer.
// An update request (now_us) gives exactly one output transfer with the
// interval, the delta and the running position.
// An update passes EVAL and COMMIT when motion is reported; when a
// zero-motion remainder is needed it also waits in DIV for the
// bit-serial remainder unit.
// Pin samples run at one per cycle while idle; one update is in flight at a time.
// The result sits in an output register: while the receiver stalls, pin
// samples and the next update are still taken; a finished update waits
// in its last step until the register frees.
// cfg_we/cfg_wdata write zero_interval; write only while idle.
// Reset: zero_interval 1000000, levels, pending delta, time base and
// position all zero, no output pending.
module quadrature_decoder_with_interval_timer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // pin_a[0], pin_b[1], now_us[33:2], zero pad
    input  logic        s_axis_tuser,  // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata   // interval_us[31:0], delta[63:32], position[95:64]
);
    import qdit_pkg::*;

    qdit_cmd_t   cmd;
    qdit_sts_t   sts;
    logic [31:0] interval_us;
    logic [31:0] delta;
    logic [31:0] position;

    qdit_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    qdit_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .pin_a       (s_axis_tdata[0]),
        .pin_b       (s_axis_tdata[1]),
        .now_us      (s_axis_tdata[33:2]),
        .interval_us (interval_us),
        .delta       (delta),
        .position    (position)
    );

    assign m_axis_tdata = {position, delta, interval_us};

endmodule
